// File: hdl/hltd_pkg.sv
// ----------------------------------------------------------------------------
// hltd_pkg: shared types and constants of the head/length/tail deframer
// Byte type, result limit, frame layout and register index codes.
// ----------------------------------------------------------------------------
package hltd_pkg;

  typedef logic [7:0] byte_t;

  // Results per received byte at most, and the width that counts them
  localparam int MaxResults = 64;
  localparam int ResW       = $clog2(MaxResults + 1);

  // Frame layout: head pair, 16-bit length, payload, tail pair
  localparam int FrameOverhead = 6;
  localparam int LenFieldEnd   = 4;
  localparam int HeadBytes     = 2;
  localparam int TailBytes     = 2;
  localparam int TotalW        = 17;

  // Configuration register indexes
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgHeadFirst  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgHeadSecond = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgTailFirst  = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgTailSecond = 8'd3;

  // Register reset values
  localparam byte_t HeadFirstReset  = 8'h93;
  localparam byte_t HeadSecondReset = 8'h00;
  localparam byte_t TailFirstReset  = 8'h00;
  localparam byte_t TailSecondReset = 8'h00;

  // Result kinds
  localparam logic EvFrameByte = 1'b0;
  localparam logic EvOverlong  = 1'b1;

endpackage

// File: hdl/hltd_if.sv
// ----------------------------------------------------------------------------
// hltd_if: valid/ready channels of the head/length/tail deframer
// Receive byte channel, frame result channel and register write channel.
// ----------------------------------------------------------------------------
interface hltd_rx_if;
  logic            valid;
  logic            ready;
  hltd_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hltd_frame_if;
  logic            valid;
  logic            ready;
  hltd_pkg::byte_t frame_byte;
  logic            frame_end;
  logic            event_kind;

  modport source (output valid, output frame_byte, output frame_end,
                  output event_kind, input ready);
  modport sink   (input valid, input frame_byte, input frame_end,
                  input event_kind, output ready);
endinterface

interface hltd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [hltd_pkg::CfgIdxW-1:0]         reg_index;
  hltd_pkg::byte_t                      reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// File: hdl/head_length_tail_deframer_unit.sv
// ----------------------------------------------------------------------------
// head_length_tail_deframer_unit: length-prefixed frame deframer
// Collects received bytes in a circular buffer, hunts for the head pair,
// checks the tail pair, emits whole frames byte by byte and reports overlong ones.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       payload
//  rx_i      in   valid / ready   rx_byte
//  frame_o   out  valid / ready   frame_byte, frame_end, event_kind
//  cfg_i     in   valid / ready   reg_index, reg_data (ready always high)
//
//  One byte is taken per step; ready stays low until the step is finished.
//  A step hunts from the front of the buffer, reading one buffer byte per
//  cycle through the single RAM read port, and stops at the first head
//  pair; a head with enough bytes held goes on to the length fetch and
//  check, then to the tail check. Each frame byte is emitted by a RAM read
//  and an output load, plus any stall on frame_o; a bad tail costs one
//  more hunt over the buffer.
//  Reset empties the buffer at once (pointer and count); no clearing pass.
// ----------------------------------------------------------------------------
module head_length_tail_deframer_unit #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  hltd_rx_if.sink              rx_i,
  hltd_frame_if.source         frame_o,
  hltd_cfg_if.sink             cfg_i
);
  import hltd_pkg::*;

  localparam int AW    = $clog2(BUFFER_BYTES);
  localparam int CW    = $clog2(BUFFER_BYTES + 1);
  localparam int Limit = (BUFFER_BYTES < MaxResults) ? BUFFER_BYTES : MaxResults;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HUNT,
    ST_LEN_A,
    ST_LEN_B,
    ST_LEN_C,
    ST_CHECK,
    ST_TAIL_A,
    ST_TAIL_B,
    ST_TAIL_C,
    ST_EMIT_ADDR,
    ST_EMIT_OUT
  } state_e;

  // Advance a buffer pointer by n, wrapping once at the buffer size
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] b, logic [CW-1:0] n);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(n);
    if (s >= (CW+1)'(BUFFER_BYTES)) begin
      s = s - (CW+1)'(BUFFER_BYTES);
    end
    return s[AW-1:0];
  endfunction

  // Buffer RAM
  byte_t mem [BUFFER_BYTES];
  byte_t rdata_q;
  logic  wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Sequencer and buffer bookkeeping
  state_e state_q, state_d;
  logic [AW-1:0]     base_q, base_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     rlog_q, rlog_d;
  logic              rv_q, rv_d;
  logic              prev_ok_q, prev_ok_d;
  byte_t             prev_q, prev_d;
  byte_t             len_lo_q, len_lo_d;
  logic [TotalW-1:0] total_q, total_d;
  logic              tail_ok_q, tail_ok_d;
  logic [ResW-1:0]   nres_q, nres_d;

  // Registers
  byte_t head0_q, head0_d, head1_q, head1_d;
  byte_t tail0_q, tail0_d, tail1_q, tail1_d;

  // Output stage
  logic  out_valid_q, out_valid_d;
  byte_t out_byte_q, out_byte_d;
  logic  out_end_q, out_end_d;
  logic  out_kind_q, out_kind_d;

  logic rx_xfer;
  logic cfg_xfer;
  logic slot_free;

  assign rx_xfer   = rx_i.valid && rx_i.ready;
  assign cfg_xfer  = cfg_i.valid && cfg_i.ready;
  assign slot_free = !out_valid_q || frame_o.ready;
  assign rd_addr   = wrap_add(base_q, idx_q);

  assign rx_i.ready         = (state_q == ST_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign frame_o.valid      = out_valid_q;
  assign frame_o.frame_byte = out_byte_q;
  assign frame_o.frame_end  = out_end_q;
  assign frame_o.event_kind = out_kind_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= rx_i.rx_byte;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    logic          hunt_go;
    logic          load;
    logic [CW-1:0] pos;
    logic [CW-1:0] remain;

    state_d     = state_q;
    base_d      = base_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rlog_d      = rlog_q;
    rv_d        = rv_q;
    prev_ok_d   = prev_ok_q;
    prev_d      = prev_q;
    len_lo_d    = len_lo_q;
    total_d     = total_q;
    tail_ok_d   = tail_ok_q;
    nres_d      = nres_q;
    head0_d     = head0_q;
    head1_d     = head1_q;
    tail0_d     = tail0_q;
    tail1_d     = tail1_q;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    out_kind_d  = out_kind_q;
    wr_en       = 1'b0;
    wr_addr     = wrap_add(base_q, count_q);
    hunt_go     = 1'b0;
    load        = 1'b0;
    pos         = rlog_q - CW'(1);
    remain      = count_q - pos;

    // Register writes land in any state; unknown indexes are dropped
    if (cfg_xfer) begin
      case (cfg_i.reg_index)
        CfgHeadFirst:  head0_d = cfg_i.reg_data;
        CfgHeadSecond: head1_d = cfg_i.reg_data;
        CfgTailFirst:  tail0_d = cfg_i.reg_data;
        CfgTailSecond: tail1_d = cfg_i.reg_data;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (rx_xfer) begin
          wr_en = 1'b1;
          if (count_q == CW'(BUFFER_BYTES)) begin
            // Full: overwrite the oldest slot and advance past it
            wr_addr = base_q;
            base_d  = wrap_add(base_q, CW'(1));
          end else begin
            count_d = count_q + CW'(1);
          end
          nres_d  = '0;
          hunt_go = 1'b1;
          state_d = ST_HUNT;
        end
      end

      ST_HUNT: begin
        // Stream the buffer from its front, one byte per cycle
        rv_d   = (idx_q < count_q);
        rlog_d = idx_q;
        if (idx_q < count_q) begin
          idx_d = idx_q + CW'(1);
        end
        if (rv_q) begin
          if (prev_ok_q && prev_q == head0_q && rdata_q == head1_q) begin
            // Head at pos: drop the garbage in front of it
            base_d  = wrap_add(base_q, pos);
            count_d = remain;
            if (remain < CW'(LenFieldEnd)) begin
              state_d = ST_IDLE;
            end else begin
              idx_d   = CW'(HeadBytes);
              state_d = ST_LEN_A;
            end
          end else begin
            prev_d    = rdata_q;
            prev_ok_d = 1'b1;
          end
        end else if (idx_q >= count_q) begin
          // No head: keep only the last byte, it may start one
          if (count_q > CW'(1)) begin
            base_d  = wrap_add(base_q, count_q - CW'(1));
            count_d = CW'(1);
          end
          state_d = ST_IDLE;
        end
      end

      ST_LEN_A: begin
        idx_d   = CW'(HeadBytes + 1);
        state_d = ST_LEN_B;
      end

      ST_LEN_B: begin
        len_lo_d = rdata_q;
        state_d  = ST_LEN_C;
      end

      ST_LEN_C: begin
        total_d = TotalW'(FrameOverhead) + TotalW'({rdata_q, len_lo_q});
        state_d = ST_CHECK;
      end

      ST_CHECK: begin
        if (total_q > TotalW'(Limit)) begin
          // Overlong: report it once, drop the head and hunt again
          if (nres_q >= ResW'(MaxResults)) begin
            state_d = ST_IDLE;
          end else if (slot_free) begin
            load       = 1'b1;
            out_byte_d = '0;
            out_end_d  = 1'b0;
            out_kind_d = EvOverlong;
            nres_d     = nres_q + ResW'(1);
            base_d     = wrap_add(base_q, CW'(HeadBytes));
            count_d    = count_q - CW'(HeadBytes);
            hunt_go    = 1'b1;
            state_d    = ST_HUNT;
          end
        end else if (TotalW'(count_q) < total_q) begin
          state_d = ST_IDLE;
        end else begin
          idx_d   = CW'(total_q - TotalW'(TailBytes));
          state_d = ST_TAIL_A;
        end
      end

      ST_TAIL_A: begin
        idx_d   = CW'(total_q - TotalW'(1));
        state_d = ST_TAIL_B;
      end

      ST_TAIL_B: begin
        tail_ok_d = (rdata_q == tail0_q);
        state_d   = ST_TAIL_C;
      end

      ST_TAIL_C: begin
        if (!tail_ok_q || rdata_q != tail1_q) begin
          // Bad tail: drop the head and rescan what is held
          base_d  = wrap_add(base_q, CW'(HeadBytes));
          count_d = count_q - CW'(HeadBytes);
          hunt_go = 1'b1;
          state_d = ST_HUNT;
        end else if ((TotalW'(nres_q) + total_q) > TotalW'(MaxResults)) begin
          // Hold the frame for a later step
          state_d = ST_IDLE;
        end else begin
          idx_d   = '0;
          state_d = ST_EMIT_ADDR;
        end
      end

      ST_EMIT_ADDR: begin
        state_d = ST_EMIT_OUT;
      end

      ST_EMIT_OUT: begin
        if (slot_free) begin
          load       = 1'b1;
          out_byte_d = rdata_q;
          out_end_d  = ((TotalW'(idx_q) + TotalW'(1)) == total_q);
          out_kind_d = EvFrameByte;
          nres_d     = nres_q + ResW'(1);
          if ((TotalW'(idx_q) + TotalW'(1)) == total_q) begin
            base_d  = wrap_add(base_q, CW'(total_q));
            count_d = count_q - CW'(total_q);
            hunt_go = 1'b1;
            state_d = ST_HUNT;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = ST_EMIT_ADDR;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (hunt_go) begin
      idx_d     = '0;
      rv_d      = 1'b0;
      prev_ok_d = 1'b0;
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      rlog_q      <= '0;
      rv_q        <= 1'b0;
      prev_ok_q   <= 1'b0;
      prev_q      <= '0;
      len_lo_q    <= '0;
      total_q     <= '0;
      tail_ok_q   <= 1'b0;
      nres_q      <= '0;
      head0_q     <= HeadFirstReset;
      head1_q     <= HeadSecondReset;
      tail0_q     <= TailFirstReset;
      tail1_q     <= TailSecondReset;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_end_q   <= 1'b0;
      out_kind_q  <= EvFrameByte;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rlog_q      <= rlog_d;
      rv_q        <= rv_d;
      prev_ok_q   <= prev_ok_d;
      prev_q      <= prev_d;
      len_lo_q    <= len_lo_d;
      total_q     <= total_d;
      tail_ok_q   <= tail_ok_d;
      nres_q      <= nres_d;
      head0_q     <= head0_d;
      head1_q     <= head1_d;
      tail0_q     <= tail0_d;
      tail1_q     <= tail1_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_end_q   <= out_end_d;
      out_kind_q  <= out_kind_d;
    end
  end

`ifndef SYNTHESIS
  // Buffer bookkeeping stays within the RAM
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(BUFFER_BYTES))
    else $error("pending count exceeds buffer size");

  a_base_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q < AW'(BUFFER_BYTES - 1) || base_q == AW'(BUFFER_BYTES - 1))
    else $error("buffer front pointer out of range");

  // A received byte always starts a step
  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_xfer |=> state_q != ST_IDLE)
    else $error("accepted byte did not start a step");

  // The per-step result budget is never overrun
  a_result_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= ResW'(MaxResults))
    else $error("result count exceeds limit");

  // Drop events carry no byte and no end mark
  a_drop_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == EvOverlong) |-> (out_byte_q == '0 && !out_end_q))
    else $error("drop event with frame payload");
`endif

endmodule
